// ----- hw/rtl/tcc_pkg.sv -----
// tcc_pkg: shared types and constants for the touch coordinate calibrator
// used by tcc_serial_mul, tcc_serial_div and touch_coordinate_calibrator
`default_nettype none

package tcc_pkg;

   // field widths
   localparam int COORD_W    = 12;
   localparam int RAW_W      = 12;
   localparam int SUM_W      = 15;
   localparam int PROD_W     = 24;
   localparam int ORIENT_W   = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   // serial divider sizes
   localparam int DIVIDEND_W = PROD_W;
   localparam int DIVISOR_W  = COORD_W;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_X_RAW_MIN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_X_RAW_MAX   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_Y_RAW_MIN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_Y_RAW_MAX   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH_M1    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT_M1   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_ORIENTATION = 3'd6;

   // orientation bits
   localparam int ORIENT_INV_X = 0;
   localparam int ORIENT_INV_Y = 1;
   localparam int ORIENT_SWAP  = 2;

   // register reset values
   localparam logic [RAW_W-1:0]    RST_X_RAW_MIN = 12'd200;
   localparam logic [RAW_W-1:0]    RST_X_RAW_MAX = 12'd3700;
   localparam logic [RAW_W-1:0]    RST_Y_RAW_MIN = 12'd200;
   localparam logic [RAW_W-1:0]    RST_Y_RAW_MAX = 12'd3700;
   localparam logic [COORD_W-1:0]  RST_WIDTH_M1  = 12'd319;
   localparam logic [COORD_W-1:0]  RST_HEIGHT_M1 = 12'd239;
   localparam logic [ORIENT_W-1:0] RST_ORIENT    = 3'd0;

   // one touch poll
   typedef struct packed {
      logic             pen_down;
      logic [RAW_W-1:0] x_sample_a;
      logic [RAW_W-1:0] x_sample_b;
      logic [RAW_W-1:0] x_sample_c;
      logic [RAW_W-1:0] x_sample_d;
      logic [RAW_W-1:0] y_sample_a;
      logic [RAW_W-1:0] y_sample_b;
      logic [RAW_W-1:0] y_sample_c;
      logic [RAW_W-1:0] y_sample_d;
   } req_type;

   // one calibrated result
   typedef struct packed {
      logic [COORD_W-1:0] screen_x;
      logic [COORD_W-1:0] screen_y;
      logic               pressed;
   } rsp_type;

endpackage

`default_nettype wire

// ----- hw/rtl/tcc_serial_mul.sv -----
// tcc_serial_mul: shift-and-add unsigned multiplier, one multiplier bit per cycle
// depends on tcc_pkg for widths
`default_nettype none

module tcc_serial_mul (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [tcc_pkg::COORD_W-1:0]    multiplicand,
   input  wire logic [tcc_pkg::COORD_W-1:0]    multiplier,
   output logic                                done,
   output logic [tcc_pkg::PROD_W-1:0]          product
);
   import tcc_pkg::*;

   localparam int STEP_CNT_W = $clog2(COORD_W);
   localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(COORD_W - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic [COORD_W-1:0]    mcand_ff, mcand_in;
   logic [COORD_W-1:0]    hi_ff, hi_in;
   logic [COORD_W-1:0]    lo_ff, lo_in;
   logic [COORD_W:0]      partial;

   // add the multiplicand into the high half when the low bit is set, then shift right
   always_comb begin
      partial  = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mcand_ff} : '0);
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      mcand_in = mcand_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         mcand_in = multiplicand;
         hi_in    = '0;
         lo_in    = multiplier;
      end else if (busy_ff) begin
         hi_in  = partial[COORD_W:1];
         lo_in  = {partial[0], lo_ff[COORD_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath shift registers
   always_ff @(posedge clock) begin
      mcand_ff <= mcand_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
   end

   assign done    = done_ff;
   assign product = {hi_ff, lo_ff};

endmodule

`default_nettype wire

// ----- hw/rtl/tcc_serial_div.sv -----
// tcc_serial_div: restoring unsigned divider, one quotient bit per cycle
// depends on tcc_pkg for widths; divisor must be nonzero
`default_nettype none

module tcc_serial_div (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [tcc_pkg::DIVIDEND_W-1:0]  dividend,
   input  wire logic [tcc_pkg::DIVISOR_W-1:0]   divisor,
   output logic                                 done,
   output logic [tcc_pkg::DIVIDEND_W-1:0]       quotient
);
   import tcc_pkg::*;

   localparam int STEP_CNT_W = $clog2(DIVIDEND_W);
   localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(DIVIDEND_W - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W+1:0]  trial;
   logic                  fits;

   // trial subtract of the divisor from the shifted remainder
   always_comb begin
      shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
      trial   = {1'b0, shifted} - {2'b00, dsr_ff};
      fits    = ~trial[DIVISOR_W+1];
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dsr_in  = divisor;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // dividend / quotient shift register and partial remainder
   always_ff @(posedge clock) begin
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/touch_coordinate_calibrator.sv -----
// touch_coordinate_calibrator: top level, sequencer and calibration registers
// depends on tcc_pkg, tcc_serial_mul and tcc_serial_div
// pen down: results are computed with one shared bit-serial divider (average, then mapping)
//   and a bit-serial multiplier
// pen up or down, one poll is processed at a time
// a new poll is taken only in idle; the result register frees the input side early
// reset: synchronous; calibration registers return to their defaults, held coordinates clear to 0
`default_nettype none

module touch_coordinate_calibrator #(
   parameter int SAMPLE_COUNT = 4,
   parameter int RAW_BITS     = 12
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire tcc_pkg::req_type                   req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output tcc_pkg::rsp_type                        rsp_data,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [tcc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [tcc_pkg::CSR_DATA_W-1:0]     csr_data
);
   import tcc_pkg::*;

   // sequencer codes
   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_ACC      = 4'd1;
   localparam logic [3:0] ST_AVG_GO   = 4'd2;
   localparam logic [3:0] ST_AVG_WAIT = 4'd3;
   localparam logic [3:0] ST_MUL_GO   = 4'd4;
   localparam logic [3:0] ST_MUL_WAIT = 4'd5;
   localparam logic [3:0] ST_DIV_GO   = 4'd6;
   localparam logic [3:0] ST_DIV_WAIT = 4'd7;
   localparam logic [3:0] ST_POST     = 4'd8;
   localparam logic [3:0] ST_FINISH   = 4'd9;

   localparam int CNT_W = 3;
   localparam logic [CNT_W-1:0] LAST_SAMPLE = CNT_W'(SAMPLE_COUNT - 1);
   localparam logic [RAW_W-1:0] RAW_MASK =
      (RAW_BITS >= RAW_W) ? {RAW_W{1'b1}} : RAW_W'((32'd1 << RAW_BITS) - 32'd1);
   localparam logic [DIVISOR_W-1:0] AVG_DIVISOR = DIVISOR_W'(SAMPLE_COUNT);

   // calibration registers
   logic [RAW_W-1:0]    x_min_ff, y_min_ff, x_max_ff, y_max_ff;
   logic [COORD_W-1:0]  width_m1_ff, height_m1_ff;
   logic [ORIENT_W-1:0] orient_ff;

   // sequencer and datapath registers
   logic [3:0]         state_ff, state_in;
   logic               axis_ff, axis_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [COORD_W-1:0] avg_ff, avg_in;
   logic [COORD_W-1:0] mapped_ff, mapped_in;
   logic [COORD_W-1:0] tx_ff, tx_in;
   logic [COORD_W-1:0] ty_ff, ty_in;
   logic [COORD_W-1:0] held_x_ff, held_x_in;
   logic [COORD_W-1:0] held_y_ff, held_y_in;
   req_type            req_ff, req_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // per-axis selections and arithmetic
   logic [RAW_W-1:0]      sample, lo, hi;
   logic [COORD_W-1:0]    ext, inverted;
   logic                  inv;
   logic [RAW_W:0]        diff, diff_neg, span, span_neg;
   logic [COORD_W-1:0]    diff_mag, span_mag;
   logic                  result_neg;
   logic                  accept, rsp_free;

   // shared unit connections
   logic                  mul_start, mul_done;
   logic [PROD_W-1:0]     product;
   logic                  div_start, div_done;
   logic [DIVIDEND_W-1:0] dividend, quotient;
   logic [DIVISOR_W-1:0]  divisor;

   tcc_serial_mul u_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start),
      .multiplicand (diff_mag),
      .multiplier   (ext),
      .done         (mul_done),
      .product      (product)
   );

   tcc_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   // configuration writes, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_min_ff     <= RST_X_RAW_MIN;
         x_max_ff     <= RST_X_RAW_MAX;
         y_min_ff     <= RST_Y_RAW_MIN;
         y_max_ff     <= RST_Y_RAW_MAX;
         width_m1_ff  <= RST_WIDTH_M1;
         height_m1_ff <= RST_HEIGHT_M1;
         orient_ff    <= RST_ORIENT;
      end else if (csr_valid) begin
         case (csr_index)
            REG_X_RAW_MIN:   x_min_ff     <= csr_data;
            REG_X_RAW_MAX:   x_max_ff     <= csr_data;
            REG_Y_RAW_MIN:   y_min_ff     <= csr_data;
            REG_Y_RAW_MAX:   y_max_ff     <= csr_data;
            REG_WIDTH_M1:    width_m1_ff  <= csr_data;
            REG_HEIGHT_M1:   height_m1_ff <= csr_data;
            REG_ORIENTATION: orient_ff    <= csr_data[ORIENT_W-1:0];
            default: ;
         endcase
      end
   end

   // sample picked cyclically from the four fields of the current axis
   always_comb begin
      case ({axis_ff, cnt_ff[1:0]})
         3'b000:  sample = req_ff.x_sample_a;
         3'b001:  sample = req_ff.x_sample_b;
         3'b010:  sample = req_ff.x_sample_c;
         3'b011:  sample = req_ff.x_sample_d;
         3'b100:  sample = req_ff.y_sample_a;
         3'b101:  sample = req_ff.y_sample_b;
         3'b110:  sample = req_ff.y_sample_c;
         default: sample = req_ff.y_sample_d;
      endcase
   end

   // calibration of the current axis
   always_comb begin
      lo  = axis_ff ? y_min_ff : x_min_ff;
      hi  = axis_ff ? y_max_ff : x_max_ff;
      ext = axis_ff ? height_m1_ff : width_m1_ff;
      inv = axis_ff ? orient_ff[ORIENT_INV_Y] : orient_ff[ORIENT_INV_X];

      diff       = {1'b0, avg_ff} - {1'b0, lo};
      diff_neg   = '0 - diff;
      diff_mag   = diff[RAW_W] ? diff_neg[COORD_W-1:0] : diff[COORD_W-1:0];
      span       = {1'b0, hi} - {1'b0, lo};
      span_neg   = '0 - span;
      span_mag   = span[RAW_W] ? span_neg[COORD_W-1:0] : span[COORD_W-1:0];
      result_neg = diff[RAW_W] ^ span[RAW_W];
      inverted   = ext - mapped_ff;
   end

   // multiplier start and divider operand selection: average first, then the mapping
   always_comb begin
      mul_start = (state_ff == ST_MUL_GO) && (span_mag != '0);
      div_start = (state_ff == ST_AVG_GO) || (state_ff == ST_DIV_GO);
      if (state_ff == ST_AVG_GO) begin
         dividend = {{(DIVIDEND_W - SUM_W){1'b0}}, sum_ff};
         divisor  = AVG_DIVISOR;
      end else begin
         dividend = product;
         divisor  = span_mag;
      end
   end

   // handshakes
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      cnt_in       = cnt_ff;
      sum_in       = sum_ff;
      avg_in       = avg_ff;
      mapped_in    = mapped_ff;
      tx_in        = tx_ff;
      ty_in        = ty_ff;
      held_x_in    = held_x_ff;
      held_y_in    = held_y_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in  = req_data;
               axis_in = 1'b0;
               cnt_in  = '0;
               sum_in  = '0;
               state_in = req_data.pen_down ? ST_ACC : ST_FINISH;
            end
         end
         ST_ACC: begin
            sum_in = sum_ff + {{(SUM_W - RAW_W){1'b0}}, sample & RAW_MASK};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_SAMPLE) begin
               state_in = ST_AVG_GO;
            end
         end
         ST_AVG_GO: begin
            state_in = ST_AVG_WAIT;
         end
         ST_AVG_WAIT: begin
            if (div_done) begin
               avg_in   = quotient[COORD_W-1:0];
               state_in = ST_MUL_GO;
            end
         end
         ST_MUL_GO: begin
            // equal calibration ends map to zero
            if (span_mag == '0) begin
               mapped_in = '0;
               state_in  = ST_POST;
            end else begin
               state_in = ST_MUL_WAIT;
            end
         end
         ST_MUL_WAIT: begin
            if (mul_done) begin
               state_in = ST_DIV_GO;
            end
         end
         ST_DIV_GO: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            // signed quotient clamped to 0..extent
            if (div_done) begin
               if (result_neg || (quotient == '0)) begin
                  mapped_in = '0;
               end else if (quotient > {{(DIVIDEND_W - COORD_W){1'b0}}, ext}) begin
                  mapped_in = ext;
               end else begin
                  mapped_in = quotient[COORD_W-1:0];
               end
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            // optional inversion within the axis's own extent
            if (axis_ff) begin
               ty_in    = inv ? inverted : mapped_ff;
               state_in = ST_FINISH;
            end else begin
               tx_in    = inv ? inverted : mapped_ff;
               axis_in  = 1'b1;
               cnt_in   = '0;
               sum_in   = '0;
               state_in = ST_ACC;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in     = 1'b1;
               rsp_in.pressed   = req_ff.pen_down;
               rsp_in.screen_x  = held_x_ff;
               rsp_in.screen_y  = held_y_ff;
               if (req_ff.pen_down) begin
                  held_x_in = orient_ff[ORIENT_SWAP] ? ty_ff : tx_ff;
                  held_y_in = orient_ff[ORIENT_SWAP] ? tx_ff : ty_ff;
                  rsp_in.screen_x = held_x_in;
                  rsp_in.screen_y = held_y_in;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= 1'b0;
         cnt_ff       <= '0;
         held_x_ff    <= '0;
         held_y_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         cnt_ff       <= cnt_in;
         held_x_ff    <= held_x_in;
         held_y_ff    <= held_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sum_ff    <= sum_in;
      avg_ff    <= avg_in;
      mapped_ff <= mapped_in;
      tx_ff     <= tx_in;
      ty_ff     <= ty_in;
      req_ff    <= req_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire
